/* design/ilt_pkg.sv */
// shared types and constants for the line tokenizer
`default_nettype none

package ilt_pkg;

    // byte values with a syntactic meaning
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // character classes found by the front end
    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_AT    = 3'd1;
    localparam logic [2:0] CLS_SEMI  = 3'd2;
    localparam logic [2:0] CLS_EQ    = 3'd3;
    localparam logic [2:0] CLS_COLON = 3'd4;
    localparam logic [2:0] CLS_SPACE = 3'd5;

    // byte roles
    localparam logic [2:0] ROLE_SEP     = 3'd0;
    localparam logic [2:0] ROLE_KEY     = 3'd1;
    localparam logic [2:0] ROLE_VALUE   = 3'd2;
    localparam logic [2:0] ROLE_SOURCE  = 3'd3;
    localparam logic [2:0] ROLE_COMMAND = 3'd4;
    localparam logic [2:0] ROLE_MIDDLE  = 3'd5;
    localparam logic [2:0] ROLE_TRAIL   = 3'd6;

    // parser phases
    localparam logic [3:0] PH_LINE_START  = 4'd0;
    localparam logic [3:0] PH_ENTRY_START = 4'd1;
    localparam logic [3:0] PH_KEY         = 4'd2;
    localparam logic [3:0] PH_VALUE_START = 4'd3;
    localparam logic [3:0] PH_VALUE       = 4'd4;
    localparam logic [3:0] PH_AFTER_TAGS  = 4'd5;
    localparam logic [3:0] PH_SRC_START   = 4'd6;
    localparam logic [3:0] PH_SRC         = 4'd7;
    localparam logic [3:0] PH_AFTER_SRC   = 4'd8;
    localparam logic [3:0] PH_COMMAND     = 4'd9;
    localparam logic [3:0] PH_PARAM_GAP   = 4'd10;
    localparam logic [3:0] PH_MIDDLE      = 4'd11;
    localparam logic [3:0] PH_TRAIL_START = 4'd12;
    localparam logic [3:0] PH_TRAIL       = 4'd13;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic [2:0] cls;
    } ilt_item_t;

    // one tokenizer result
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] role;
        logic       start;
        logic [3:0] pidx;
        logic       done;
        logic       ok;
    } ilt_result_t;

endpackage

`default_nettype wire

/* design/ilt_classify.sv */
// front end: sorts each incoming byte into a character class
`default_nettype none

module ilt_classify
    import ilt_pkg::*;
(
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_line,
    output ilt_item_t       item
);

    logic [2:0] cls;

    always_comb
    begin
        case (data_byte)
            CH_AT:    cls = CLS_AT;
            CH_SEMI:  cls = CLS_SEMI;
            CH_EQ:    cls = CLS_EQ;
            CH_COLON: cls = CLS_COLON;
            CH_SPACE: cls = CLS_SPACE;
            default:  cls = CLS_OTHER;
        endcase
    end

    assign item.data = data_byte;
    assign item.eol  = end_of_line;
    assign item.cls  = cls;

endmodule

`default_nettype wire

/* design/ilt_queue.sv */
// short register queue between classifier and parser
`default_nettype none

module ilt_queue
    import ilt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire ilt_item_t wr_item,
    output logic           full,
    input  wire logic      rd_en,
    output ilt_item_t      rd_item,
    output logic           valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    ilt_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == DEPTH_CNT);
    assign valid   = (count_reg != '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* design/ilt_parse.sv */
// back end: line parser state machine and result register
`default_nettype none

module ilt_parse
    import ilt_pkg::*;
#(
    parameter int MAX_PARAMS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire ilt_item_t in_item,
    output logic           in_take,
    output logic           res_valid,
    output ilt_result_t    res,
    input  wire logic      res_pop
);

    localparam logic [3:0] INDEX_CAP = (MAX_PARAMS >= 16) ? 4'd15 : 4'(MAX_PARAMS - 1);

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  pcount_reg, pcount_next;
    logic        cmd_seen_reg, cmd_seen_next;
    logic        out_valid_reg, out_valid_next;
    ilt_result_t out_reg;
    ilt_result_t res_next;

    logic [3:0] ph;
    logic [3:0] pc;
    logic       cs;
    logic [2:0] role;
    logic       start;
    logic [3:0] pidx;
    logic [2:0] cls;

    assign cls     = in_item.cls;
    assign in_take = in_valid && (!out_valid_reg || res_pop);

    always_comb
    begin
        ph    = phase_reg;
        pc    = pcount_reg;
        cs    = cmd_seen_reg;
        role  = ROLE_SEP;
        start = 1'b0;
        pidx  = 4'd0;
        case (phase_reg)
            PH_LINE_START:
            begin
                if (cls == CLS_AT)
                    ph = PH_ENTRY_START;
                else if (cls == CLS_COLON)
                    ph = PH_SRC_START;
                else if (cls == CLS_SPACE)
                    ph = PH_PARAM_GAP;
                else
                begin
                    role = ROLE_COMMAND; start = 1'b1; cs = 1'b1; ph = PH_COMMAND;
                end
            end
            PH_ENTRY_START, PH_KEY:
            begin
                if (cls == CLS_SEMI)
                    ph = PH_ENTRY_START;
                else if (cls == CLS_SPACE)
                    ph = PH_AFTER_TAGS;
                else if (cls == CLS_EQ)
                    ph = PH_VALUE_START;
                else
                begin
                    role = ROLE_KEY; start = (phase_reg == PH_ENTRY_START); ph = PH_KEY;
                end
            end
            PH_VALUE_START, PH_VALUE:
            begin
                if (cls == CLS_SEMI)
                    ph = PH_ENTRY_START;
                else if (cls == CLS_SPACE)
                    ph = PH_AFTER_TAGS;
                else
                begin
                    role = ROLE_VALUE; start = (phase_reg == PH_VALUE_START);
                    ph = PH_VALUE;
                end
            end
            PH_AFTER_TAGS:
            begin
                if (cls == CLS_SPACE)
                    ph = PH_AFTER_TAGS;
                else if (cls == CLS_COLON)
                    ph = PH_SRC_START;
                else
                begin
                    role = ROLE_COMMAND; start = 1'b1; cs = 1'b1; ph = PH_COMMAND;
                end
            end
            PH_SRC_START, PH_SRC:
            begin
                if (cls == CLS_SPACE)
                    ph = PH_AFTER_SRC;
                else
                begin
                    role = ROLE_SOURCE; start = (phase_reg == PH_SRC_START); ph = PH_SRC;
                end
            end
            PH_AFTER_SRC:
            begin
                if (cls != CLS_SPACE)
                begin
                    role = ROLE_COMMAND; start = 1'b1; cs = 1'b1; ph = PH_COMMAND;
                end
            end
            PH_COMMAND:
            begin
                if (cls == CLS_SPACE)
                    ph = PH_PARAM_GAP;
                else
                    role = ROLE_COMMAND;
            end
            PH_PARAM_GAP:
            begin
                if (cls == CLS_SPACE)
                    ph = PH_PARAM_GAP;
                else if (cls == CLS_COLON)
                begin
                    pidx = pcount_reg; ph = PH_TRAIL_START;
                end
                else
                begin
                    role = ROLE_MIDDLE; start = 1'b1; pidx = pcount_reg; ph = PH_MIDDLE;
                end
            end
            PH_MIDDLE:
            begin
                if (cls == CLS_SPACE)
                begin
                    // saturating parameter count
                    if (pcount_reg < INDEX_CAP)
                        pc = pcount_reg + 4'd1;
                    ph = PH_PARAM_GAP;
                end
                else
                begin
                    role = ROLE_MIDDLE; pidx = pcount_reg;
                end
            end
            PH_TRAIL_START, PH_TRAIL:
            begin
                role  = ROLE_TRAIL;
                start = (phase_reg == PH_TRAIL_START);
                pidx  = pcount_reg;
                ph    = PH_TRAIL;
            end
            default:
            begin
                ph = PH_LINE_START;
            end
        endcase

        res_next.data  = in_item.data;
        res_next.role  = role;
        res_next.start = start;
        res_next.pidx  = pidx;
        res_next.done  = in_item.eol;
        res_next.ok    = in_item.eol & cs;

        phase_next    = phase_reg;
        pcount_next   = pcount_reg;
        cmd_seen_next = cmd_seen_reg;
        if (in_take)
        begin
            if (in_item.eol)
            begin
                phase_next    = PH_LINE_START;
                pcount_next   = 4'd0;
                cmd_seen_next = 1'b0;
            end
            else
            begin
                phase_next    = ph;
                pcount_next   = pc;
                cmd_seen_next = cs;
            end
        end

        out_valid_next = out_valid_reg;
        if (in_take)
            out_valid_next = 1'b1;
        else if (res_pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            pcount_reg    <= 4'd0;
            cmd_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pcount_reg    <= pcount_next;
            cmd_seen_reg  <= cmd_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

/* design/irc_line_tokenizer_unit.sv */
// top level of the byte-serial chat line tokenizer
// accepted bytes go through the queue, then into the result register
// throughput: one byte per cycle while results are popped as they appear
// the classifier writes into a four-entry queue, so the input keeps flowing while
// results back up, until that queue and the result register are both full
// reset: asynchronous, empties the queue and result register, parser state to line start
`default_nettype none

module irc_line_tokenizer_unit
    import ilt_pkg::*;
#(
    parameter int MAX_PARAMS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input side, queue style
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_line,
    // result side, queue style
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic [2:0]      byte_role,
    output logic            field_start,
    output logic [3:0]      param_index,
    output logic            line_done,
    output logic            line_ok
);

    ilt_item_t   cls_item;
    ilt_item_t   q_item;
    logic        q_full;
    logic        q_valid;
    logic        q_take;
    logic        res_valid;
    ilt_result_t res;
    logic        in_transaction;

    // a transaction is taken only when the queue has room
    assign in_transaction = push && !q_full;
    assign full           = q_full;

    // front end: character classification
    ilt_classify u_classify (
        .data_byte   (data_byte),
        .end_of_line (end_of_line),
        .item        (cls_item)
    );

    // decoupling queue between classification and parsing
    ilt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_transaction),
        .wr_item (cls_item),
        .full    (q_full),
        .rd_en   (q_take),
        .rd_item (q_item),
        .valid   (q_valid)
    );

    // back end: parser state and result register, which can refill in the
    // same cycle that its current result is popped
    ilt_parse #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_take   (q_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty       = !res_valid;
    assign out_byte    = res.data;
    assign byte_role   = res.role;
    assign field_start = res.start;
    assign param_index = res.pidx;
    assign line_done   = res.done;
    assign line_ok     = res.ok;

    // line status only ever appears on the closing byte of a line
    a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && line_ok) |-> line_done)
        else $error("line_ok set on a byte that does not end the line");

    // separators never open a field
    a_sep_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_role == ROLE_SEP) |-> !field_start)
        else $error("separator byte marked as field start");

    // key, value, source and command bytes carry index zero
    a_pidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (byte_role == ROLE_KEY || byte_role == ROLE_VALUE ||
                    byte_role == ROLE_SOURCE || byte_role == ROLE_COMMAND))
        |-> (param_index == 4'd0))
        else $error("non-parameter byte carries a parameter index");

endmodule

`default_nettype wire
